FILE: rtl/core/phm_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// phm_pkg - shared types and constants of the pulse-height to MIP converter
// Field widths, word selects, result kinds and the pipeline payload structs.
// ---------------------------------------------------------------------------
package phm_pkg;

   // Table size and field widths
   localparam int unsigned CHANNELS_DEF = 256;
   localparam int unsigned CH_W         = 8;
   localparam int unsigned PHA_W        = 12;
   localparam int unsigned SEL_W        = 3;
   localparam int unsigned WORD_W       = 16;
   localparam int unsigned WORDS        = 5;
   localparam int unsigned MIPS_W       = 17;
   localparam int unsigned REQ_TDATA_W  = 40;
   localparam int unsigned RSP_TDATA_W  = 24;

   // Datapath widths
   localparam int unsigned DIFF_W     = 18;                // pha*16 - ped, sat - r
   localparam int unsigned MAG_W      = 16;                // |pha*16 - ped|
   localparam int unsigned DEN_W      = 32;                // divisor, partial remainder
   localparam int unsigned QUO_W      = 17;                // quotient bits, one per cell
   localparam int unsigned FRAC_SHIFT = 6;                 // Q.4 in, Q.6 out
   localparam int unsigned NUM_W      = DEN_W + FRAC_SHIFT;
   localparam int unsigned HEAD_W     = NUM_W - QUO_W;

   // Request kinds
   localparam logic OP_CONVERT = 1'b0;
   localparam logic OP_LOAD    = 1'b1;

   // Calibration word selects
   localparam logic [SEL_W-1:0] WSEL_LO_PED = 3'd0;
   localparam logic [SEL_W-1:0] WSEL_GAIN   = 3'd1;
   localparam logic [SEL_W-1:0] WSEL_HI_PED = 3'd2;
   localparam logic [SEL_W-1:0] WSEL_SLOPE  = 3'd3;
   localparam logic [SEL_W-1:0] WSEL_SAT    = 3'd4;
   localparam logic [SEL_W-1:0] WSEL_LIMIT  = 3'd5;

   // Output constants, Q11.6
   localparam logic [MIPS_W-1:0] MIPS_ZERO    = 17'h00000;
   localparam logic [MIPS_W-1:0] MIPS_POS_SAT = 17'h0FFFF;
   localparam logic [MIPS_W-1:0] MIPS_NEG_SAT = 17'h10000;
   localparam logic [MIPS_W-1:0] HI_FLOOR     = 17'd192;    // 3.0
   localparam logic [MIPS_W-1:0] HI_MIN       = 17'd224;    // 3.5
   localparam logic [MIPS_W-1:0] HI_CEIL      = 17'd64000;  // 1000.0

   // 50 counts in Q.4
   localparam logic [DIFF_W-2:0] SAT_MARGIN = 17'd800;

   // How the final value is formed
   typedef enum logic [2:0] {
      KIND_DIV,
      KIND_ZERO,
      KIND_POS_SAT,
      KIND_NEG_SAT,
      KIND_FLOOR,
      KIND_CEIL,
      KIND_HI_MIN
   } phm_kind_type;

   // Convert request with its calibration words
   typedef struct packed {
      logic              ok;
      logic              hi;
      logic [PHA_W-1:0]  pha;
      logic [WORD_W-1:0] lo_ped;
      logic [WORD_W-1:0] gain;
      logic [WORD_W-1:0] hi_ped;
      logic [WORD_W-1:0] slope;
      logic [WORD_W-1:0] sat;
   } phm_cal_type;

   // Control carried alongside the divider
   typedef struct packed {
      logic         ok;
      logic         hi;
      logic         neg;
      phm_kind_type kind;
   } phm_tag_type;

   // Divider cell payload; acc holds remaining dividend bits, quotient shifts in
   typedef struct packed {
      phm_tag_type      tag;
      logic             ovf;
      logic [DEN_W-1:0] den;
      logic [DEN_W-1:0] rem;
      logic [QUO_W-1:0] acc;
   } phm_div_type;

endpackage
`default_nettype wire

FILE: rtl/core/phm_cal_table.sv
`default_nettype none
// ---------------------------------------------------------------------------
// phm_cal_table - calibration word store
// Five word memories plus five valid-bit memories; loads write, converts read
// and leave a registered request with its words and an ok flag. After reset
// a clearing pass zeroes the valid bits, one channel per cycle.
// ---------------------------------------------------------------------------
module phm_cal_table #(
   parameter int unsigned CHANNELS = phm_pkg::CHANNELS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic                              op,
   input  logic [phm_pkg::CH_W-1:0]          channel,
   input  logic                              range_high,
   input  logic [phm_pkg::PHA_W-1:0]         pulse_height,
   input  logic [phm_pkg::SEL_W-1:0]         word_select,
   input  logic [phm_pkg::WORD_W-1:0]        word_value,
   output logic                              out_valid,
   input  logic                              out_ready,
   output phm_pkg::phm_cal_type              out_data
);

   localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int unsigned EXT_W = IDX_W + phm_pkg::CH_W;

   logic [EXT_W-1:0]                 ch_ext;
   logic [IDX_W-1:0]                 idx;
   logic                             in_range;
   logic                             accept;
   logic                             load_en;
   logic                             conv_en;

   logic                             clearing_ff;
   logic [IDX_W-1:0]                 clear_idx_ff;
   logic                             clear_last;

   logic                             lo_ped_vld_mem [CHANNELS];
   logic                             gain_vld_mem [CHANNELS];
   logic                             hi_ped_vld_mem [CHANNELS];
   logic                             slope_vld_mem [CHANNELS];
   logic                             sat_vld_mem [CHANNELS];

   logic [phm_pkg::WORD_W-1:0]       lo_ped_mem [CHANNELS];
   logic [phm_pkg::WORD_W-1:0]       gain_mem [CHANNELS];
   logic [phm_pkg::WORD_W-1:0]       hi_ped_mem [CHANNELS];
   logic [phm_pkg::WORD_W-1:0]       slope_mem [CHANNELS];
   logic [phm_pkg::WORD_W-1:0]       sat_mem [CHANNELS];

   logic                             out_valid_ff;
   logic                             in_range_ff;
   logic                             lo_ped_vld_ff;
   logic                             gain_vld_ff;
   logic                             hi_ped_vld_ff;
   logic                             slope_vld_ff;
   logic                             sat_vld_ff;
   logic                             hi_ff;
   logic [phm_pkg::PHA_W-1:0]        pha_ff;
   logic [phm_pkg::WORD_W-1:0]       lo_ped_ff;
   logic [phm_pkg::WORD_W-1:0]       gain_ff;
   logic [phm_pkg::WORD_W-1:0]       hi_ped_ff;
   logic [phm_pkg::WORD_W-1:0]       slope_ff;
   logic [phm_pkg::WORD_W-1:0]       sat_ff;

   // Channel range check and table index
   assign ch_ext   = {{IDX_W{1'b0}}, channel};
   assign idx      = ch_ext[IDX_W-1:0];
   assign in_range = ch_ext < EXT_W'(CHANNELS);

   assign in_ready = !clearing_ff && (!out_valid_ff || out_ready);
   assign accept   = in_valid && in_ready;
   assign load_en  = accept && (op == phm_pkg::OP_LOAD) && in_range
                     && (word_select < phm_pkg::WSEL_LIMIT);
   assign conv_en  = accept && (op == phm_pkg::OP_CONVERT);

   // Clearing pass over the valid bits after reset
   assign clear_last = (clear_idx_ff == IDX_W'(CHANNELS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clear_idx_ff <= '0;
      end else if (clearing_ff) begin
         clearing_ff  <= !clear_last;
         clear_idx_ff <= clear_idx_ff + IDX_W'(1);
      end
   end

   // Valid-bit memories: cleared by the pass, set by loads, registered read
   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         lo_ped_vld_mem[clear_idx_ff] <= 1'b0;
         gain_vld_mem[clear_idx_ff]   <= 1'b0;
         hi_ped_vld_mem[clear_idx_ff] <= 1'b0;
         slope_vld_mem[clear_idx_ff]  <= 1'b0;
         sat_vld_mem[clear_idx_ff]    <= 1'b0;
      end else begin
         if (load_en && (word_select == phm_pkg::WSEL_LO_PED)) lo_ped_vld_mem[idx] <= 1'b1;
         if (load_en && (word_select == phm_pkg::WSEL_GAIN))   gain_vld_mem[idx]   <= 1'b1;
         if (load_en && (word_select == phm_pkg::WSEL_HI_PED)) hi_ped_vld_mem[idx] <= 1'b1;
         if (load_en && (word_select == phm_pkg::WSEL_SLOPE))  slope_vld_mem[idx]  <= 1'b1;
         if (load_en && (word_select == phm_pkg::WSEL_SAT))    sat_vld_mem[idx]    <= 1'b1;
      end
      if (conv_en) begin
         lo_ped_vld_ff <= lo_ped_vld_mem[idx];
         gain_vld_ff   <= gain_vld_mem[idx];
         hi_ped_vld_ff <= hi_ped_vld_mem[idx];
         slope_vld_ff  <= slope_vld_mem[idx];
         sat_vld_ff    <= sat_vld_mem[idx];
         in_range_ff   <= in_range;
      end
   end

   // Word memories: one write and one registered read per cycle each
   always_ff @(posedge clock) begin
      if (load_en && (word_select == phm_pkg::WSEL_LO_PED)) lo_ped_mem[idx] <= word_value;
      if (load_en && (word_select == phm_pkg::WSEL_GAIN))   gain_mem[idx]   <= word_value;
      if (load_en && (word_select == phm_pkg::WSEL_HI_PED)) hi_ped_mem[idx] <= word_value;
      if (load_en && (word_select == phm_pkg::WSEL_SLOPE))  slope_mem[idx]  <= word_value;
      if (load_en && (word_select == phm_pkg::WSEL_SAT))    sat_mem[idx]    <= word_value;
      if (conv_en) begin
         lo_ped_ff <= lo_ped_mem[idx];
         gain_ff   <= gain_mem[idx];
         hi_ped_ff <= hi_ped_mem[idx];
         slope_ff  <= slope_mem[idx];
         sat_ff    <= sat_mem[idx];
         hi_ff     <= range_high;
         pha_ff    <= pulse_height;
      end
   end

   // Stage occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (in_ready) begin
         out_valid_ff <= conv_en;
      end
   end

   // Needed words: low range 0 and 1, high range 2, 3 and 4
   assign out_data.ok     = in_range_ff
                            && (hi_ff ? (hi_ped_vld_ff && slope_vld_ff && sat_vld_ff)
                                      : (lo_ped_vld_ff && gain_vld_ff));

   assign out_valid       = out_valid_ff;
   assign out_data.hi     = hi_ff;
   assign out_data.pha    = pha_ff;
   assign out_data.lo_ped = lo_ped_ff;
   assign out_data.gain   = gain_ff;
   assign out_data.hi_ped = hi_ped_ff;
   assign out_data.slope  = slope_ff;
   assign out_data.sat    = sat_ff;

endmodule
`default_nettype wire

FILE: rtl/core/phm_prep.sv
`default_nettype none
// ---------------------------------------------------------------------------
// phm_prep - operand preparation for the divider chain
// Three stages: pedestal subtract, products and classification, then the
// quotient overflow check that seeds the first divider cell.
// ---------------------------------------------------------------------------
module phm_prep (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  phm_pkg::phm_cal_type in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output phm_pkg::phm_div_type out_data
);

   typedef struct packed {
      logic                        ok;
      logic                        hi;
      logic [phm_pkg::DIFF_W-1:0]  r;
      logic [phm_pkg::DIFF_W-1:0]  from_sat;
      logic [phm_pkg::WORD_W-1:0]  gain;
      logic [phm_pkg::WORD_W-1:0]  slope;
      logic [phm_pkg::WORD_W-1:0]  sat;
   } s2_type;

   typedef struct packed {
      phm_pkg::phm_tag_type        tag;
      logic [phm_pkg::DEN_W-1:0]   num;
      logic [phm_pkg::DEN_W-1:0]   den;
   } s3_type;

   logic                        s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic                        s2_ready, s3_ready, s4_ready;
   s2_type                      s2_in, s2_ff;
   s3_type                      s3_in, s3_ff;
   phm_pkg::phm_div_type        s4_in, s4_ff;

   logic [phm_pkg::WORD_W-1:0]  ped;
   logic [phm_pkg::DIFF_W-1:0]  pha_q4;
   logic                        neg;
   logic [phm_pkg::DIFF_W-1:0]  r_neg;
   logic [phm_pkg::MAG_W-1:0]   mag;
   logic                        r_zero;
   logic                        near_sat;
   logic [phm_pkg::DEN_W-1:0]   top;
   logic [phm_pkg::DEN_W-1:0]   bot;
   logic [phm_pkg::NUM_W-1:0]   numer;
   logic [phm_pkg::DEN_W-1:0]   head;

   // Backpressure: a stage takes new data when empty or draining
   assign s4_ready = !s4_valid_ff || out_ready;
   assign s3_ready = !s3_valid_ff || s4_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign in_ready = s2_ready;

   // Stage 2: r = pha*16 - ped and distance to saturation
   always_comb begin
      ped            = in_data.hi ? in_data.hi_ped : in_data.lo_ped;
      pha_q4         = {2'b00, in_data.pha, 4'b0000};
      s2_in.ok       = in_data.ok;
      s2_in.hi       = in_data.hi;
      s2_in.r        = pha_q4 - {2'b00, ped};
      s2_in.from_sat = {2'b00, in_data.sat} + {2'b00, ped} - pha_q4;
      s2_in.gain     = in_data.gain;
      s2_in.slope    = in_data.slope;
      s2_in.sat      = in_data.sat;
   end

   // Stage 3: products for the high range, magnitude for the low range
   always_comb begin
      neg      = s2_ff.r[phm_pkg::DIFF_W-1];
      r_neg    = -s2_ff.r;
      mag      = neg ? r_neg[phm_pkg::MAG_W-1:0] : s2_ff.r[phm_pkg::MAG_W-1:0];
      r_zero   = (s2_ff.r == '0);
      near_sat = s2_ff.from_sat[phm_pkg::DIFF_W-1]
                 || (s2_ff.from_sat[phm_pkg::DIFF_W-2:0] < phm_pkg::SAT_MARGIN);
      top      = phm_pkg::DEN_W'(s2_ff.sat) * phm_pkg::DEN_W'(s2_ff.r[phm_pkg::MAG_W-1:0]);
      bot      = phm_pkg::DEN_W'(s2_ff.slope)
                 * phm_pkg::DEN_W'(s2_ff.from_sat[phm_pkg::MAG_W-1:0]);

      s3_in.tag.ok  = s2_ff.ok;
      s3_in.tag.hi  = s2_ff.hi;
      s3_in.tag.neg = neg;
      if (!s2_ff.ok) begin
         s3_in.tag.kind = phm_pkg::KIND_ZERO;
      end else if (!s2_ff.hi) begin
         // zero gain saturates by sign of the numerator
         if (s2_ff.gain != '0)  s3_in.tag.kind = phm_pkg::KIND_DIV;
         else if (r_zero)       s3_in.tag.kind = phm_pkg::KIND_ZERO;
         else if (neg)          s3_in.tag.kind = phm_pkg::KIND_NEG_SAT;
         else                   s3_in.tag.kind = phm_pkg::KIND_POS_SAT;
      end else begin
         // below pedestal, near saturation, zero slope, else divide
         if (neg)                     s3_in.tag.kind = phm_pkg::KIND_FLOOR;
         else if (near_sat)           s3_in.tag.kind = phm_pkg::KIND_CEIL;
         else if (s2_ff.slope != '0)  s3_in.tag.kind = phm_pkg::KIND_DIV;
         else if (r_zero)             s3_in.tag.kind = phm_pkg::KIND_HI_MIN;
         else                         s3_in.tag.kind = phm_pkg::KIND_CEIL;
      end

      s3_in.num = s2_ff.hi ? top : {{(phm_pkg::DEN_W-phm_pkg::MAG_W){1'b0}}, mag};
      s3_in.den = s2_ff.hi ? bot : {{(phm_pkg::DEN_W-phm_pkg::WORD_W){1'b0}}, s2_ff.gain};
   end

   // Stage 4: dividend = num*64; quotient too large if head >= den
   always_comb begin
      numer     = {s3_ff.num, {phm_pkg::FRAC_SHIFT{1'b0}}};
      head      = {{(phm_pkg::DEN_W-phm_pkg::HEAD_W){1'b0}},
                   numer[phm_pkg::NUM_W-1:phm_pkg::QUO_W]};
      s4_in.tag = s3_ff.tag;
      s4_in.ovf = (head >= s3_ff.den);
      s4_in.den = s3_ff.den;
      s4_in.rem = head;
      s4_in.acc = numer[phm_pkg::QUO_W-1:0];
   end

   // Occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (s2_ready) s2_valid_ff <= in_valid;
         if (s3_ready) s3_valid_ff <= s2_valid_ff;
         if (s4_ready) s4_valid_ff <= s3_valid_ff;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (s2_ready) s2_ff <= s2_in;
      if (s3_ready) s3_ff <= s3_in;
      if (s4_ready) s4_ff <= s4_in;
   end

   assign out_valid = s4_valid_ff;
   assign out_data  = s4_ff;

endmodule
`default_nettype wire

FILE: rtl/core/phm_div_cell.sv
`default_nettype none
// ---------------------------------------------------------------------------
// phm_div_cell - one restoring divider cell
// Brings down one dividend bit, subtracts the divisor when it fits and
// shifts the quotient bit in; registered, with its own occupancy flag.
// ---------------------------------------------------------------------------
module phm_div_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  phm_pkg::phm_div_type in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output phm_pkg::phm_div_type out_data
);

   logic                        valid_ff;
   phm_pkg::phm_div_type        data_in, data_ff;
   logic [phm_pkg::DEN_W:0]     trial;
   logic [phm_pkg::DEN_W+1:0]   diff;
   logic                        fits;

   assign in_ready = !valid_ff || out_ready;

   // Partial remainder step
   always_comb begin
      trial       = {in_data.rem, in_data.acc[phm_pkg::QUO_W-1]};
      diff        = {1'b0, trial} - {2'b00, in_data.den};
      fits        = !diff[phm_pkg::DEN_W+1];
      data_in     = in_data;
      data_in.rem = fits ? diff[phm_pkg::DEN_W-1:0] : trial[phm_pkg::DEN_W-1:0];
      data_in.acc = {in_data.acc[phm_pkg::QUO_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

FILE: rtl/core/pulse_height_to_mip_converter_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// pulse_height_to_mip_converter_core - pulse height to MIP converter
// Calibration table with load and convert requests; converts run through a
// chain of divider cells and leave a saturated Q11.6 value and an ok flag.
// ---------------------------------------------------------------------------
//  channel | dir | request                            | per request
//  req_    | in  | convert or load of one cal word    | none or one rsp_ request
//  rsp_    | out | MIP value and ok flag              | one per convert
//
//  One request per cycle, loads and converts alike, unless the clearing pass
//  or a full pipeline holds req_tready low. A convert passes the table read,
//  three operand stages, 17 divider cells (one quotient bit each) and the
//  output register. After reset a clearing pass zeroes the valid bits, one
//  channel a cycle; req_tready stays low until it ends. Word memories are
//  not cleared. Every stage holds while its successor is full and empty
//  stages close up, so requests keep flowing while a result waits on rsp_tready.
// ---------------------------------------------------------------------------
module pulse_height_to_mip_converter_core #(
   parameter int unsigned CHANNELS = phm_pkg::CHANNELS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // channel[7:0], range_high[8], pulse_height[20:9], word_select[23:21],
   // word_value[39:24]
   input  logic [phm_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // op: 0 convert, 1 load
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // mips[16:0], zeros[23:17]
   output logic [phm_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // ok
   output logic                               rsp_tuser
);

   logic                          cal_valid;
   logic                          cal_ready;
   phm_pkg::phm_cal_type          cal_data;

   logic [phm_pkg::QUO_W:0]       chain_valid;
   logic [phm_pkg::QUO_W:0]       chain_ready;
   phm_pkg::phm_div_type          chain_data [phm_pkg::QUO_W+1];

   phm_pkg::phm_div_type          last;
   logic [phm_pkg::QUO_W-1:0]     quo;
   logic [phm_pkg::MIPS_W-1:0]    mips_in;

   logic                          rsp_valid_ff;
   logic [phm_pkg::MIPS_W-1:0]    rsp_mips_ff;
   logic                          rsp_ok_ff;

   // Calibration store and read stage
   phm_cal_table #(
      .CHANNELS (CHANNELS)
   ) u_cal_table (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .op           (req_tuser),
      .channel      (req_tdata[7:0]),
      .range_high   (req_tdata[8]),
      .pulse_height (req_tdata[20:9]),
      .word_select  (req_tdata[23:21]),
      .word_value   (req_tdata[39:24]),
      .out_valid    (cal_valid),
      .out_ready    (cal_ready),
      .out_data     (cal_data)
   );

   // Operand preparation
   phm_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cal_valid),
      .in_ready  (cal_ready),
      .in_data   (cal_data),
      .out_valid (chain_valid[0]),
      .out_ready (chain_ready[0]),
      .out_data  (chain_data[0])
   );

   // Divider chain, most significant quotient bit first
   for (genvar k = 0; k < phm_pkg::QUO_W; k++) begin : g_cell
      phm_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[k]),
         .in_ready  (chain_ready[k]),
         .in_data   (chain_data[k]),
         .out_valid (chain_valid[k+1]),
         .out_ready (chain_ready[k+1]),
         .out_data  (chain_data[k+1])
      );
   end

   assign chain_ready[phm_pkg::QUO_W] = !rsp_valid_ff || rsp_tready;

   // Final value: fixed results, clamp or saturation of the quotient
   always_comb begin
      last = chain_data[phm_pkg::QUO_W];
      quo  = last.acc;
      case (last.tag.kind)
         phm_pkg::KIND_ZERO:    mips_in = phm_pkg::MIPS_ZERO;
         phm_pkg::KIND_POS_SAT: mips_in = phm_pkg::MIPS_POS_SAT;
         phm_pkg::KIND_NEG_SAT: mips_in = phm_pkg::MIPS_NEG_SAT;
         phm_pkg::KIND_FLOOR:   mips_in = phm_pkg::HI_FLOOR;
         phm_pkg::KIND_CEIL:    mips_in = phm_pkg::HI_CEIL;
         phm_pkg::KIND_HI_MIN:  mips_in = phm_pkg::HI_MIN;
         phm_pkg::KIND_DIV: begin
            if (last.tag.hi) begin
               if (last.ovf || (quo > phm_pkg::HI_CEIL)) mips_in = phm_pkg::HI_CEIL;
               else if (quo < phm_pkg::HI_MIN)           mips_in = phm_pkg::HI_MIN;
               else                                      mips_in = quo;
            end else if (!last.tag.neg) begin
               if (last.ovf || quo[phm_pkg::QUO_W-1])    mips_in = phm_pkg::MIPS_POS_SAT;
               else                                      mips_in = quo;
            end else begin
               // truncation toward zero: negate the magnitude quotient
               if (last.ovf || (quo > phm_pkg::MIPS_NEG_SAT)) mips_in = phm_pkg::MIPS_NEG_SAT;
               else                                           mips_in = -quo;
            end
         end
         default:               mips_in = phm_pkg::MIPS_ZERO;
      endcase
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (chain_ready[phm_pkg::QUO_W]) begin
         rsp_valid_ff <= chain_valid[phm_pkg::QUO_W];
      end
   end

   always_ff @(posedge clock) begin
      if (chain_ready[phm_pkg::QUO_W]) begin
         rsp_mips_ff <= mips_in;
         rsp_ok_ff   <= last.tag.ok;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(phm_pkg::RSP_TDATA_W-phm_pkg::MIPS_W){1'b0}}, rsp_mips_ff};
   assign rsp_tuser  = rsp_ok_ff;

endmodule
`default_nettype wire
